### hdl/fccw_pkg.sv
`timescale 1ns / 1ps

package fccw_pkg;

   localparam int TABLE_BYTES = 6144;
   localparam int MAX_RUN     = 64;

   localparam int ADDR_W      = $clog2(TABLE_BYTES);
   localparam int BYTE_ADDR_W = 13;

   localparam logic [BYTE_ADDR_W-1:0] TABLE_LIMIT = BYTE_ADDR_W'(TABLE_BYTES);
   localparam logic [6:0]             RUN_LIMIT   = 7'(MAX_RUN);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_WALK  = 1'b1;

   localparam logic [1:0] ST_SECTOR    = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;

   localparam logic [11:0] EOC_SHORT     = 12'h0FF;
   localparam logic [11:0] EOC_FULL      = 12'hFFF;
   localparam logic [11:0] CLUSTER_LIMIT = 12'hFF0;
   localparam logic [12:0] SECTOR_BIAS   = 13'd31;

   typedef struct packed {
      logic                   wr_en;
      logic [BYTE_ADDR_W-1:0] wr_addr;
      logic [7:0]             wr_data;
      logic                   rd_en;
      logic [BYTE_ADDR_W-1:0] rd_addr;
   } tbl_port_type;

endpackage

### hdl/fccw_req_if.sv
`timescale 1ns / 1ps

interface fccw_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [12:0] byte_address;
   logic [7:0]  byte_value;
   logic [11:0] start_cluster;
   logic [11:0] skip_links;
   logic [6:0]  run_length;

   modport source (output valid, opcode, byte_address, byte_value, start_cluster,
                   skip_links, run_length, input ready);
   modport sink   (input valid, opcode, byte_address, byte_value, start_cluster,
                   skip_links, run_length, output ready);
endinterface

### hdl/fccw_rsp_if.sv
`timescale 1ns / 1ps

interface fccw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [12:0] disk_sector;
   logic        last;

   modport source (output valid, status, disk_sector, last, input ready);
   modport sink   (input valid, status, disk_sector, last, output ready);
endinterface

### hdl/fat12_cluster_chain_walker.sv
`timescale 1ns / 1ps
// Write word: accepted while idle, no result.
// Walk word: accepted while idle; each skipped link and each sector needs two byte reads
// on the single table read port (states S_RD0, S_RD1, S_RD2), and each sector then waits
// in S_OUT for any output stall.
// A walk is taken only when the previous one has delivered its last result.
// Reset clears the sequencer and output valid; table contents are undefined until written.

module fat12_cluster_chain_walker (
   input  logic        clock,
   input  logic        reset,
   fccw_req_if.sink    req_ch,
   fccw_rsp_if.source  rsp_ch
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_RD0   = 3'd2;
   localparam logic [2:0] S_RD1   = 3'd3;
   localparam logic [2:0] S_RD2   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [11:0] cluster_ff, cluster_in;
   logic [11:0] skip_ff, skip_in;
   logic [6:0]  run_ff, run_in;
   logic [6:0]  count_ff, count_in;
   logic [7:0]  lo_ff, lo_in;
   logic [1:0]  status_ff, status_in;
   logic [12:0] sector_ff, sector_in;
   logic        last_ff, last_in;

   fccw_pkg::tbl_port_type         tbl_port;
   logic [7:0]                     rd_data;
   logic [fccw_pkg::BYTE_ADDR_W-1:0] base_addr;
   logic [11:0]                    next_cluster;
   logic                           req_fire;
   logic                           rsp_fire;

   fccw_table u_table (
      .clock   (clock),
      .port    (tbl_port),
      .rd_data (rd_data)
   );

   fccw_link u_link (
      .cluster      (cluster_ff),
      .lo_byte      (lo_ff),
      .hi_byte      (rd_data),
      .base_addr    (base_addr),
      .next_cluster (next_cluster)
   );

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = (state_ff == S_OUT);
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.disk_sector = sector_ff;
   assign rsp_ch.last        = last_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      tbl_port.wr_en   = req_fire && (req_ch.opcode == fccw_pkg::OP_WRITE);
      tbl_port.wr_addr = req_ch.byte_address;
      tbl_port.wr_data = req_ch.byte_value;
      tbl_port.rd_en   = (state_ff == S_RD0) || (state_ff == S_RD1);
      tbl_port.rd_addr = (state_ff == S_RD1) ? base_addr + 13'd1 : base_addr;
   end

   always_comb begin
      state_in   = state_ff;
      cluster_in = cluster_ff;
      skip_in    = skip_ff;
      run_in     = run_ff;
      count_in   = count_ff;
      lo_in      = lo_ff;
      status_in  = status_ff;
      sector_in  = sector_ff;
      last_in    = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_ch.opcode == fccw_pkg::OP_WALK)) begin
               cluster_in = req_ch.start_cluster;
               skip_in    = req_ch.skip_links;
               run_in     = (req_ch.run_length > fccw_pkg::RUN_LIMIT) ?
                            fccw_pkg::RUN_LIMIT : req_ch.run_length;
               count_in   = 7'd0;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (skip_ff != 12'd0) begin
               state_in = S_RD0;
            end else if ((count_ff == run_ff) || (cluster_ff >= fccw_pkg::CLUSTER_LIMIT)) begin
               // only reached with nothing emitted yet
               status_in = fccw_pkg::ST_EMPTY;
               sector_in = 13'd0;
               last_in   = 1'b1;
               state_in  = S_OUT;
            end else begin
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            state_in = S_RD1;
         end
         S_RD1: begin
            lo_in    = rd_data;
            state_in = S_RD2;
         end
         S_RD2: begin
            cluster_in = next_cluster;
            if (skip_ff != 12'd0) begin
               skip_in = skip_ff - 12'd1;
               if ((next_cluster == fccw_pkg::EOC_SHORT) ||
                   (next_cluster == fccw_pkg::EOC_FULL)) begin
                  status_in = fccw_pkg::ST_NOT_FOUND;
                  sector_in = 13'd0;
                  last_in   = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_CHECK;
               end
            end else begin
               // next link is known, so last can be flagged with this sector
               status_in = fccw_pkg::ST_SECTOR;
               sector_in = {1'b0, cluster_ff} + fccw_pkg::SECTOR_BIAS;
               last_in   = ((count_ff + 7'd1) == run_ff) ||
                           (next_cluster >= fccw_pkg::CLUSTER_LIMIT);
               count_in  = count_ff + 7'd1;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               state_in = last_ff ? S_IDLE : S_RD0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cluster_ff <= cluster_in;
      skip_ff    <= skip_in;
      run_ff     <= run_in;
      count_ff   <= count_in;
      lo_ff      <= lo_in;
      status_ff  <= status_in;
      sector_ff  <= sector_in;
      last_ff    <= last_in;
   end

endmodule

### hdl/fccw_table.sv
`timescale 1ns / 1ps

module fccw_table (
   input  logic                   clock,
   input  fccw_pkg::tbl_port_type port,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [fccw_pkg::TABLE_BYTES];
   logic [7:0] raw_ff;
   logic       in_range_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en && (port.wr_addr < fccw_pkg::TABLE_LIMIT)) begin
         mem[port.wr_addr[fccw_pkg::ADDR_W-1:0]] <= port.wr_data;
      end
      if (port.rd_en) begin
         raw_ff      <= mem[port.rd_addr[fccw_pkg::ADDR_W-1:0]];
         in_range_ff <= port.rd_addr < fccw_pkg::TABLE_LIMIT;
      end
   end

   // bytes past the table read as zero
   assign rd_data = in_range_ff ? raw_ff : 8'h00;

endmodule

### hdl/fccw_link.sv
`timescale 1ns / 1ps

module fccw_link (
   input  logic [11:0]                        cluster,
   input  logic [7:0]                         lo_byte,
   input  logic [7:0]                         hi_byte,
   output logic [fccw_pkg::BYTE_ADDR_W-1:0]   base_addr,
   output logic [11:0]                        next_cluster
);

   // n*3/2 for even n and (n-1)*3/2+1 for odd n both reduce to n + n/2
   assign base_addr = fccw_pkg::BYTE_ADDR_W'({1'b0, cluster})
                    + fccw_pkg::BYTE_ADDR_W'(cluster[11:1]);

   always_comb begin
      if (cluster[0]) begin
         next_cluster = {hi_byte, lo_byte[7:4]};
      end else begin
         next_cluster = {hi_byte[3:0], lo_byte};
      end
   end

endmodule
